[rtl/ppg_pkg.sv]
// shared constants, types and tables of the presieve pattern generator
`default_nettype none

package ppg_pkg;

    localparam int POS_W      = 23;   // pattern byte index
    localparam int LB_W       = 64;   // lower bound of a seek
    localparam int CNT_W      = 7;    // byte count of a fill
    localparam int LIMIT_W    = 5;    // wheel limit register
    localparam int RES_W      = 5;    // residue modulo one wheel prime
    localparam int BYTE_W     = 8;
    localparam int NUM_PRIMES = 6;
    localparam int STEP_W     = 7;
    localparam int SEEK_STEPS = LB_W;
    localparam int FILL_STEPS = POS_W;
    localparam int WHEEL_MOD  = 2 * 3 * 5;
    localparam int RES_DEPTH  = 2 ** RES_W;

    localparam int DEF_MAX_FILL_BYTES = 64;
    localparam int DEF_WHEEL_PRIMES   = 6;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(19);
    localparam logic [LIMIT_W-1:0] LIMIT_MIN   = LIMIT_W'(7);

    localparam logic ACT_SEEK = 1'b0;
    localparam logic ACT_FILL = 1'b1;

    typedef logic [NUM_PRIMES-1:0][RES_W-1:0]           t_prime_tab;
    typedef logic [BYTE_W-1:0][RES_W:0]                 t_offset_tab;
    typedef logic [NUM_PRIMES:0][POS_W-1:0]             t_period_tab;
    typedef logic [NUM_PRIMES-1:0][RES_DEPTH-1:0][BYTE_W-1:0] t_mask_tab;

    localparam t_prime_tab PRIME_TAB = {
        RES_W'(23), RES_W'(19), RES_W'(17), RES_W'(13), RES_W'(11), RES_W'(7)
    };

    // numbers 30k+off covered by bits 0 to 7
    localparam t_offset_tab OFFSET_TAB = {
        6'd31, 6'd29, 6'd23, 6'd19, 6'd17, 6'd13, 6'd11, 6'd7
    };

    // period in bytes for a given number of active primes
    localparam t_period_tab PERIOD_TAB = {
        POS_W'(7436429), POS_W'(323323), POS_W'(17017), POS_W'(1001),
        POS_W'(77), POS_W'(7), POS_W'(1)
    };

    // bit set where prime i divides 30*r + offset
    function automatic t_mask_tab build_mask_tab();
        t_mask_tab t;
        int        n;
        int        p;
        t = '0;
        for (int i = 0; i < NUM_PRIMES; i++) begin
            for (int r = 0; r < RES_DEPTH; r++) begin
                for (int b = 0; b < BYTE_W; b++) begin
                    n = WHEEL_MOD * r + int'(OFFSET_TAB[b]);
                    p = int'(PRIME_TAB[i]);
                    while (n >= p) begin
                        n = n - p;
                    end
                    t[i][r][b] = (n == 0);
                end
            end
        end
        return t;
    endfunction

    localparam t_mask_tab MASK_TAB = build_mask_tab();

    function automatic logic [LIMIT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] limit);
        return (limit < LIMIT_MIN) ? LIMIT_MIN : limit;
    endfunction

    typedef struct packed {
        logic load_seek;   // start a seek with the lower bound
        logic load_fill;   // start a fill with the stored position
        logic step;        // one bit of the modulo loop
        logic out_load;    // load the output register
        logic out_last;    // last flag for that load
        logic advance;     // step position and residues by one byte
        logic store_pos;   // write back the pattern position
    } t_dp_cmd;

endpackage

`default_nettype wire

[rtl/ppg_ctrl.sv]
// controller of the presieve pattern generator: handshakes, step and byte counters
`default_nettype none

module ppg_ctrl #(
    parameter int MAX_FILL_BYTES = ppg_pkg::DEF_MAX_FILL_BYTES
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  wire                       i_action,
    input  wire  [ppg_pkg::CNT_W-1:0] i_byte_count,
    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    output ppg_pkg::t_dp_cmd          o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    localparam logic [ppg_pkg::CNT_W-1:0] MAX_CNT = ppg_pkg::CNT_W'(MAX_FILL_BYTES);

    logic [1:0]                  r_state, n_state;
    logic [ppg_pkg::STEP_W-1:0]  r_steps, n_steps;
    logic [ppg_pkg::CNT_W-1:0]   r_remain, n_remain;
    logic                        r_seek, n_seek;
    logic                        r_out_valid, n_out_valid;
    logic [ppg_pkg::CNT_W-1:0]   sat_count;
    logic                        in_xfer;
    logic                        out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign sat_count   = (i_byte_count > MAX_CNT) ? MAX_CNT : i_byte_count;

    always_comb begin
        n_state     = r_state;
        n_steps     = r_steps;
        n_remain    = r_remain;
        n_seek      = r_seek;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_action == ppg_pkg::ACT_SEEK) begin
                        o_cmd.load_seek = 1'b1;
                        n_seek          = 1'b1;
                        n_steps         = ppg_pkg::STEP_W'(ppg_pkg::SEEK_STEPS);
                        n_state         = ST_SHIFT;
                    end else if (sat_count != '0) begin
                        o_cmd.load_fill = 1'b1;
                        n_seek          = 1'b0;
                        n_steps         = ppg_pkg::STEP_W'(ppg_pkg::FILL_STEPS);
                        n_remain        = sat_count;
                        n_state         = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                o_cmd.step = 1'b1;
                n_steps    = r_steps - 1'b1;
                if (r_steps == ppg_pkg::STEP_W'(1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    if (r_seek) begin
                        o_cmd.out_last  = 1'b1;
                        o_cmd.store_pos = 1'b1;
                        n_state         = ST_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_remain      = r_remain - 1'b1;
                        if (r_remain == ppg_pkg::CNT_W'(1)) begin
                            o_cmd.out_last  = 1'b1;
                            o_cmd.store_pos = 1'b1;
                            n_state         = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_steps     <= '0;
            r_remain    <= '0;
            r_seek      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_steps     <= n_steps;
            r_remain    <= n_remain;
            r_seek      <= n_seek;
            r_out_valid <= n_out_valid;
        end
    end

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register loaded while a result waits");

    // a seek always runs its loop before anything else is taken
    a_seek_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_action == ppg_pkg::ACT_SEEK) |=> (!o_in_ready && o_cmd.step))
        else $error("seek transfer did not start the modulo loop");

    // a fill never emits with an empty byte count
    a_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.advance |-> (r_remain != '0))
        else $error("byte emitted with no bytes remaining");

endmodule

`default_nettype wire

[rtl/ppg_datapath.sv]
// datapath of the presieve pattern generator: modulo loop, residue lanes, output register
`default_nettype none

module ppg_datapath #(
    parameter int WHEEL_PRIMES = ppg_pkg::DEF_WHEEL_PRIMES
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire  [ppg_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  wire  [ppg_pkg::LB_W-1:0]    i_lower_bound,
    input  ppg_pkg::t_dp_cmd            i_cmd,
    output logic [ppg_pkg::BYTE_W-1:0]  o_pattern_byte,
    output logic [ppg_pkg::POS_W-1:0]   o_position,
    output logic                        o_last
);

    localparam int PAD_W = ppg_pkg::LB_W - ppg_pkg::POS_W;

    logic [ppg_pkg::LIMIT_W-1:0] r_limit;
    logic [ppg_pkg::POS_W-1:0]   r_pos;
    logic [ppg_pkg::LB_W-1:0]    r_shift;
    logic [ppg_pkg::POS_W-1:0]   r_q;
    logic [ppg_pkg::RES_W-1:0]   r_s;
    logic                        r_seek;
    logic [WHEEL_PRIMES-1:0][ppg_pkg::RES_W-1:0] r_res;

    logic [ppg_pkg::LIMIT_W-1:0] lim_eff;
    logic [WHEEL_PRIMES-1:0]     active;
    logic [2:0]                  act_cnt;
    logic [ppg_pkg::POS_W-1:0]   period;
    logic                        sh_bit;
    logic [ppg_pkg::RES_W:0]     s2;
    logic                        s_ge;
    logic [ppg_pkg::RES_W-1:0]   s_next;
    logic                        c_bit;
    logic [ppg_pkg::POS_W:0]     q2;
    logic [ppg_pkg::POS_W-1:0]   q_next;
    logic [ppg_pkg::POS_W:0]     q_plus;
    logic [ppg_pkg::POS_W-1:0]   q_inc;
    logic [WHEEL_PRIMES-1:0][ppg_pkg::RES_W-1:0] res_step;
    logic [WHEEL_PRIMES-1:0][ppg_pkg::RES_W-1:0] res_inc;
    logic [ppg_pkg::BYTE_W-1:0]  kill;

    // active primes and the period they set
    assign lim_eff = ppg_pkg::eff_limit(r_limit);

    always_comb begin
        act_cnt = '0;
        for (int i = 0; i < WHEEL_PRIMES; i++) begin
            active[i] = (ppg_pkg::LIMIT_W'(ppg_pkg::PRIME_TAB[i]) <= lim_eff);
            act_cnt   = act_cnt + 3'(active[i]);
        end
    end

    assign period = ppg_pkg::PERIOD_TAB[act_cnt];

    // one bit of the modulo loop: remainder kept as 30*q + s
    assign sh_bit = r_shift[ppg_pkg::LB_W-1];
    assign s2     = {r_s, sh_bit};
    assign s_ge   = (s2 >= (ppg_pkg::RES_W+1)'(ppg_pkg::WHEEL_MOD));
    assign s_next = s_ge ? ppg_pkg::RES_W'(s2 - (ppg_pkg::RES_W+1)'(ppg_pkg::WHEEL_MOD))
                         : s2[ppg_pkg::RES_W-1:0];
    assign c_bit  = r_seek ? s_ge : sh_bit;
    assign q2     = {r_q, c_bit};
    assign q_next = (q2 >= {1'b0, period}) ? ppg_pkg::POS_W'(q2 - {1'b0, period})
                                           : q2[ppg_pkg::POS_W-1:0];

    assign q_plus = {1'b0, r_q} + 1'b1;
    assign q_inc  = (q_plus == {1'b0, period}) ? '0 : q_plus[ppg_pkg::POS_W-1:0];

    // residue lanes, one per wheel prime
    always_comb begin
        logic [ppg_pkg::RES_W:0] r2;
        logic [ppg_pkg::RES_W:0] p;
        kill = '0;
        for (int i = 0; i < WHEEL_PRIMES; i++) begin
            p  = {1'b0, ppg_pkg::PRIME_TAB[i]};
            r2 = {r_res[i], c_bit};
            res_step[i] = (r2 >= p) ? ppg_pkg::RES_W'(r2 - p) : r2[ppg_pkg::RES_W-1:0];
            res_inc[i]  = ({1'b0, r_res[i]} + 1'b1 == p) ? '0 : r_res[i] + 1'b1;
            if (active[i]) begin
                kill = kill | ppg_pkg::MASK_TAB[i][r_res[i]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ppg_pkg::LIMIT_RESET;
            r_pos   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.store_pos) begin
                r_pos <= r_seek ? r_q : q_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seek || i_cmd.load_fill) begin
            r_shift <= i_cmd.load_seek ? i_lower_bound : {r_pos, PAD_W'(0)};
            r_q     <= '0;
            r_s     <= '0;
            r_res   <= '0;
            r_seek  <= i_cmd.load_seek;
        end else if (i_cmd.step) begin
            r_shift <= {r_shift[ppg_pkg::LB_W-2:0], 1'b0};
            r_q     <= q_next;
            r_s     <= s_next;
            r_res   <= res_step;
        end else if (i_cmd.advance) begin
            r_q     <= q_inc;
            r_res   <= res_inc;
        end
        if (i_cmd.out_load) begin
            o_pattern_byte <= r_seek ? '0 : ~kill;
            o_position     <= r_q;
            o_last         <= i_cmd.out_last;
        end
    end

    // emitted positions always lie inside the period
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> (r_q < period))
        else $error("fill position outside the pattern period");

    // the seek remainder stays below the wheel modulus
    a_s_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_s < ppg_pkg::RES_W'(ppg_pkg::WHEEL_MOD)))
        else $error("seek remainder out of range");

endmodule

`default_nettype wire

[rtl/presieve_pattern_generator.sv]
// top level of the mod-30 presieve pattern generator
// usage:
//   input channel (i_in_valid / o_in_ready) takes one item per transfer:
//   i_action 0 = seek, 1 = fill, with i_lower_bound and i_byte_count
//   output channel (o_out_valid / i_out_ready) gives one pattern byte per transfer
//   a seek gives one result (byte 0, new position, last set) after a bit-serial
//   modulo loop over all 64 bits of the lower bound
//   a fill first reduces the stored position bit by bit, then emits one byte
//   per cycle while the receiver is ready
//   the modulo loop, one bit a cycle, sets the cost of both items
//   a fill with byte count 0 gives no result, counts above the maximum saturate
//   the block takes one item at a time; a new item is taken while the final
//   result of the previous one still waits in the output register
//   when the receiver stalls, emission pauses with the byte held in the output
//   register and the position frozen
//   reset: wheel limit 19, pattern position 0, output channel empty; the user
//   writes the wheel limit via i_cfg_we / i_cfg_wdata only while idle, unenforced
`default_nettype none

module presieve_pattern_generator #(
    parameter int MAX_FILL_BYTES = ppg_pkg::DEF_MAX_FILL_BYTES,
    parameter int WHEEL_PRIMES   = ppg_pkg::DEF_WHEEL_PRIMES
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // configuration write
    input  wire                         i_cfg_we,
    input  wire  [ppg_pkg::LIMIT_W-1:0] i_cfg_wdata,
    // input channel
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire                         i_action,
    input  wire  [ppg_pkg::LB_W-1:0]    i_lower_bound,
    input  wire  [ppg_pkg::CNT_W-1:0]   i_byte_count,
    // output channel
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic [ppg_pkg::BYTE_W-1:0]  o_pattern_byte,
    output logic [ppg_pkg::POS_W-1:0]   o_position,
    output logic                        o_last
);

    // commands from the controller to the datapath
    ppg_pkg::t_dp_cmd cmd;

    // handshakes, step counter and remaining byte count
    ppg_ctrl #(
        .MAX_FILL_BYTES (MAX_FILL_BYTES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_byte_count (i_byte_count),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cmd        (cmd)
    );

    // limit register, position, modulo loop, residue lanes and output register
    ppg_datapath #(
        .WHEEL_PRIMES (WHEEL_PRIMES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_lower_bound  (i_lower_bound),
        .i_cmd          (cmd),
        .o_pattern_byte (o_pattern_byte),
        .o_position     (o_position),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

[verif/presieve_pattern_generator_tb.sv]
// testbench of the presieve pattern generator: directed and random seek/fill traffic checked by a scoreboard
`default_nettype none

module presieve_pattern_generator_tb;

    localparam int POS_W         = ppg_pkg::POS_W;
    localparam int LB_W          = ppg_pkg::LB_W;
    localparam int CNT_W         = ppg_pkg::CNT_W;
    localparam int LIMIT_W       = ppg_pkg::LIMIT_W;
    localparam int BYTE_W        = ppg_pkg::BYTE_W;
    localparam int NUM_WHEEL     = 6;
    localparam int MAX_FILL      = 64;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int PHASE_ITEMS   = 42;
    localparam int NUM_PHASES    = 10;

    typedef enum logic {
        OP_SEEK = ppg_pkg::ACT_SEEK,
        OP_FILL = ppg_pkg::ACT_FILL
    } op_e;

    typedef struct packed {
        logic [BYTE_W-1:0] pattern_byte;
        logic [POS_W-1:0]  position;
        logic              last;
    } result_t;

    // wheel primes and the offsets from a multiple of 30 of bits 0 to 7, entry 0 rightmost
    localparam logic [5:0][4:0] SIEVE_PRIMES = {
        5'd23, 5'd19, 5'd17, 5'd13, 5'd11, 5'd7
    };
    localparam logic [7:0][5:0] BIT_OFFSETS = {
        6'd31, 6'd29, 6'd23, 6'd19, 6'd17, 6'd13, 6'd11, 6'd7
    };

    // expected pattern bytes, worked out from the wheel limit and the stored position
    class pattern_scoreboard;
        logic [LIMIT_W-1:0] wheel_limit;
        logic [POS_W-1:0]   next_position;
        result_t            expected_q[$];
        int                 errors;

        function new();
            wheel_limit   = ppg_pkg::LIMIT_RESET;
            next_position = '0;
            errors        = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] value);
            wheel_limit = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit prime_active(int i);
            logic [LIMIT_W-1:0] lim;
            lim = (wheel_limit < ppg_pkg::LIMIT_MIN) ? ppg_pkg::LIMIT_MIN : wheel_limit;
            return (i < NUM_WHEEL) && (SIEVE_PRIMES[i] <= lim);
        endfunction

        // bytes after which the pattern repeats
        function int unsigned period_bytes();
            int unsigned per;
            per = 1;
            for (int i = 0; i < NUM_WHEEL; i++) begin
                if (prime_active(i)) per = per * SIEVE_PRIMES[i];
            end
            return per;
        endfunction

        function logic [BYTE_W-1:0] pattern_at(int unsigned pos);
            logic [BYTE_W-1:0] bits;
            longint unsigned   n;
            bits = '1;
            for (int b = 0; b < BYTE_W; b++) begin
                n = longint'(pos) * 30 + BIT_OFFSETS[b];
                for (int i = 0; i < NUM_WHEEL; i++) begin
                    if (prime_active(i) && (n % SIEVE_PRIMES[i]) == 0) bits[b] = 1'b0;
                end
            end
            return bits;
        endfunction

        function void note_item(op_e op, logic [LB_W-1:0] lower_bound,
                                logic [CNT_W-1:0] byte_count);
            int unsigned     per;
            int unsigned     pos;
            int unsigned     count;
            longint unsigned span;
            result_t         r;
            per = period_bytes();
            if (op == OP_SEEK) begin
                span          = longint'(per) * 30;
                next_position = POS_W'((lower_bound % span) / 30);
                r.pattern_byte = '0;
                r.position     = next_position;
                r.last         = 1'b1;
                expected_q.push_back(r);
            end else begin
                // a stale position from an older, longer period is folded first
                pos   = next_position % per;
                count = (byte_count > MAX_FILL) ? MAX_FILL : byte_count;
                for (int unsigned k = 0; k < count; k++) begin
                    r.pattern_byte = pattern_at(pos);
                    r.position     = POS_W'(pos);
                    r.last         = (k + 1 == count);
                    expected_q.push_back(r);
                    pos = (pos + 1 >= per) ? 0 : pos + 1;
                end
                // an empty fill leaves the position untouched
                if (count != 0) next_position = POS_W'(pos);
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %h position %0d last %b",
                                          got.pattern_byte, got.position, got.last));
                return;
            end
            want = expected_q.pop_front();
            if (got.pattern_byte !== want.pattern_byte)
                report_mismatch($sformatf("pattern byte %h, expected %h at position %0d",
                                          got.pattern_byte, want.pattern_byte, want.position));
            if (got.position !== want.position)
                report_mismatch($sformatf("position %0d, expected %0d",
                                          got.position, want.position));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, expected %b at position %0d",
                                          got.last, want.last, want.position));
        endtask
    endclass

    // block ports
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wdata   = '0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic               i_action      = OP_SEEK;
    logic [LB_W-1:0]    i_lower_bound = '0;
    logic [CNT_W-1:0]   i_byte_count  = '0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b1;
    logic [BYTE_W-1:0]  o_pattern_byte;
    logic [POS_W-1:0]   o_position;
    logic               o_last;

    pattern_scoreboard sb;

    // idling odds: one in n chance per slot, 0 turns the idling off
    int gap_odds   = 0;
    int stall_odds = 0;
    int stall_left = 0;
    int cycle_count = 0;

    presieve_pattern_generator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_lower_bound  (i_lower_bound),
        .i_byte_count   (i_byte_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pattern_byte (o_pattern_byte),
        .o_position     (o_position),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: ready drops at random, in bursts of random length
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) i_out_ready <= 1'b1;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(1, 11);
        end
    end

    // output transfers: sampled mid-cycle, the transfer lands at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            sb.check_result(result_t'({o_pattern_byte, o_position, o_last}));
    end

    // one input transfer, with a random gap in front of it
    task automatic send_item(input op_e op, input logic [LB_W-1:0] lower_bound,
                             input logic [CNT_W-1:0] byte_count);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= op;
        i_lower_bound <= lower_bound;
        i_byte_count  <= byte_count;
        do @(negedge i_clk); while (o_in_ready !== 1'b1);
        @(posedge i_clk);
        sb.note_item(op, lower_bound, byte_count);
    endtask

    // hold off the sender until every expected byte is out and the block is quiet
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_limit(value);
    endtask

    task automatic send_random_item();
        logic [LB_W-1:0]  lower_bound;
        logic [CNT_W-1:0] byte_count;
        longint unsigned  span;
        int               pick;
        lower_bound = {$urandom, $urandom};
        byte_count  = CNT_W'($urandom_range(1, 16));
        if ($urandom_range(0, 9) < 3) begin
            pick = $urandom_range(0, 3);
            if (pick == 1) begin
                lower_bound = LB_W'($urandom_range(0, 65535));
            end else if (pick == 2) begin
                // just below a period boundary, so following fills wrap
                span        = longint'(sb.period_bytes()) * 30;
                lower_bound = span * $urandom_range(1, 1000) - $urandom_range(1, 90);
            end else if (pick == 3) begin
                lower_bound = '1 - LB_W'($urandom_range(0, 1023));
            end
            send_item(OP_SEEK, lower_bound, byte_count);
        end else begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                byte_count = '0;
            else if (pick == 1)
                byte_count = CNT_W'($urandom_range(65, 127));
            else if (pick < 5)
                byte_count = CNT_W'($urandom_range(17, 64));
            send_item(OP_FILL, lower_bound, byte_count);
        end
    endtask

    initial begin
        logic [LIMIT_W-1:0] phase_limits [NUM_PHASES];
        phase_limits = '{5'd31, 5'd12, 5'd23, 5'd7, 5'd17, 5'd11, 5'd13, 5'd24, 5'd0, 5'd19};
        sb = new();
        gap_odds   = 5;
        stall_odds = 5;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limit 19: fills from position 0, empty and oversized counts
        send_item(OP_FILL, '0, 7'd1);
        send_item(OP_FILL, '1, 7'd64);
        send_item(OP_FILL, '0, 7'd0);
        send_item(OP_FILL, '0, 7'd127);
        send_item(OP_FILL, '0, 7'd65);
        // seeks at the extremes of the lower bound
        send_item(OP_SEEK, '0, 7'd0);
        send_item(OP_SEEK, '1, 7'd127);
        send_item(OP_FILL, '0, 7'd2);
        // two bytes before the end of the period, then a fill across the wrap
        send_item(OP_SEEK, 64'd323321 * 30 + 29, 7'd1);
        send_item(OP_FILL, '0, 7'd5);
        send_item(OP_SEEK, 64'h8000_0000_0000_0000, 7'd0);
        send_item(OP_FILL, '0, 7'd3);

        // limit below seven with a stored position past the new period
        send_item(OP_SEEK, 64'd300000 * 30, 7'd0);
        drain_results();
        write_limit(5'd0);
        send_item(OP_FILL, '0, 7'd10);

        // limit above twenty-three: longest period, wrap at its end
        drain_results();
        write_limit(5'd31);
        send_item(OP_SEEK, 64'd7436428 * 30 + 1, 7'd0);
        send_item(OP_FILL, '0, 7'd3);
        send_item(OP_SEEK, '1, 7'd0);
        send_item(OP_FILL, '0, 7'd64);

        // random phases, one wheel limit each, with varying idling
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_limit(phase_limits[p]);
            case (p % 3)
                0: begin
                    gap_odds   = 0;
                    stall_odds = 0;
                end
                1: begin
                    gap_odds   = 3;
                    stall_odds = 3;
                end
                default: begin
                    gap_odds   = 10;
                    stall_odds = 10;
                end
            endcase
            // no idling in the closing phase
            if (p == NUM_PHASES - 1) begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) send_random_item();
        end

        drain_results();
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/ppg_pkg.sv
rtl/ppg_ctrl.sv
rtl/ppg_datapath.sv
rtl/presieve_pattern_generator.sv
verif/presieve_pattern_generator_tb.sv
